// ===== rtl/core/pf_pkg.sv =====
// shared constants and types for the prime factorizer
`timescale 1ns / 1ps

package pf_pkg;

    // default sizes
    localparam int WIDTH_DEF       = 16;
    localparam int MAX_FACTORS_DEF = 16;

    // width of one emitted factor
    localparam int FACTOR_W = 16;

    // status from the serial divider back to the sequencer
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_status;

endpackage

// ===== rtl/core/pf_divider.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pf_divider #(
    parameter int WIDTH = pf_pkg::WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [WIDTH-1:0]   i_dividend,
    input  logic [WIDTH-1:0]   i_divisor,
    output logic [WIDTH-1:0]   o_quotient,
    output pf_pkg::t_div_status o_status
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [WIDTH:0]   w_shift;
    logic             w_ge;
    logic [WIDTH:0]   w_diff;
    logic [WIDTH-1:0] n_rem;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        w_shift = {r_rem, r_quo[WIDTH-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
        n_rem   = w_ge ? w_diff[WIDTH-1:0] : w_shift[WIDTH-1:0];
    end

    // control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(WIDTH);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[WIDTH-2:0], w_ge};
        end
    end

    assign o_quotient        = r_quo;
    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule

// ===== rtl/core/prime_factorizer.sv =====
// prime factorizer top level: trial division sequencer, factor store, output register
//
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_value
// result    out        o_valid / i_ready    o_factor, o_last, o_no_factors
//
// one item at a time; each trial divisor goes through a check, a divider start,
// WIDTH serial divider steps and done, whether it divides or not.
// results then leave one per cycle while i_ready is high, greatest factor first; an input
// below two gives a single no-factors result. o_ready is high only between items.
// synchronous active-low reset clears control; the output register holds under stall.
`timescale 1ns / 1ps

module prime_factorizer #(
    parameter int WIDTH       = pf_pkg::WIDTH_DEF,
    parameter int MAX_FACTORS = pf_pkg::MAX_FACTORS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [WIDTH-1:0]            i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pf_pkg::FACTOR_W-1:0] o_factor,
    output logic                        o_last,
    output logic                        o_no_factors
);

    localparam int FW   = pf_pkg::FACTOR_W;
    localparam int SW   = WIDTH + 1;
    localparam int CW   = $clog2(MAX_FACTORS + 1);
    localparam int IW   = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NONE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic [WIDTH-1:0]    r_n;
    logic [WIDTH-1:0]    r_d;
    logic [SW-1:0]       r_dsq;
    logic [CW-1:0]       r_count;
    logic                r_div_start;
    logic                r_o_valid;
    logic [FW-1:0]       r_o_factor;
    logic                r_o_last;
    logic                r_o_no_factors;

    logic [FW-1:0]       r_store [MAX_FACTORS];

    logic [WIDTH-1:0]    w_quotient;
    pf_pkg::t_div_status w_status;

    logic                w_slot_free;
    logic                w_past_root;
    logic                w_wr_en;
    logic [WIDTH-1:0]    w_wr_src;
    logic [WIDTH+FW-1:0] w_wr_ext;
    logic [FW-1:0]       w_wr_data;
    logic [CW-1:0]       w_rd_cnt;
    logic [IW-1:0]       w_rd_idx;
    logic [SW-1:0]       n_dsq;

    // serial divider for each trial
    pf_divider #(
        .WIDTH (WIDTH)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_quotient (w_quotient),
        .o_status   (w_status)
    );

    // trial control, store write and read addressing
    always_comb begin
        w_slot_free = !r_o_valid || i_ready;
        w_past_root = (r_dsq > {1'b0, r_n});
        w_wr_en     = 1'b0;
        w_wr_src    = r_d;
        if (r_state == ST_CHECK && w_past_root && r_n > WIDTH'(1)) begin
            w_wr_en  = 1'b1;
            w_wr_src = r_n;
        end else if (r_state == ST_DIV && w_status.done && w_status.rem_zero) begin
            w_wr_en  = 1'b1;
            w_wr_src = r_d;
        end
        // drop factors once the store is full
        if (r_count >= CW'(MAX_FACTORS)) begin
            w_wr_en = 1'b0;
        end
        w_wr_ext  = {{FW{1'b0}}, w_wr_src};
        w_wr_data = w_wr_ext[FW-1:0];
        w_rd_cnt  = r_count - CW'(1);
        w_rd_idx  = w_rd_cnt[IW-1:0];
        // next square: (d+1)^2 = d^2 + 2d + 1
        n_dsq     = r_dsq + {r_d, 1'b0} + SW'(1);
    end

    // factor store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[r_count[IW-1:0]] <= w_wr_data;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_div_start <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_wr_en) begin
                r_count <= r_count + CW'(1);
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_n     <= i_value;
                        r_d     <= WIDTH'(2);
                        r_dsq   <= SW'(4);
                        r_count <= '0;
                        r_state <= (i_value < WIDTH'(2)) ? ST_NONE : ST_CHECK;
                    end
                end
                ST_NONE: begin
                    if (w_slot_free) begin
                        r_o_valid      <= 1'b1;
                        r_o_factor     <= '0;
                        r_o_last       <= 1'b1;
                        r_o_no_factors <= 1'b1;
                        r_state        <= ST_IDLE;
                    end
                end
                ST_CHECK: begin
                    if (w_past_root) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_status.done) begin
                        if (w_status.rem_zero) begin
                            r_n <= w_quotient;
                        end else begin
                            r_d   <= r_d + WIDTH'(1);
                            r_dsq <= n_dsq;
                        end
                        r_state <= ST_CHECK;
                    end
                end
                ST_EMIT: begin
                    if (w_slot_free) begin
                        r_o_valid      <= 1'b1;
                        r_o_factor     <= r_store[w_rd_idx];
                        r_o_last       <= (r_count == CW'(1));
                        r_o_no_factors <= 1'b0;
                        r_count        <= w_rd_cnt;
                        if (r_count == CW'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_o_valid;
    assign o_factor     = r_o_factor;
    assign o_last       = r_o_last;
    assign o_no_factors = r_o_no_factors;

endmodule
